>>> hw/rtl/hav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine distance package
// Shared widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hav_pkg;

    localparam int CORDIC_STAGES_DEF = 32;

    // Width of the signed angle and CORDIC datapath (Q2.30 plus headroom).
    localparam int AW = 34;

    localparam logic [31:0] PI_Q30_U     = 32'd3373259426;
    localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [AW-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [AW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [30:0] HALF_TURN    = 31'd1800000000;
    localparam logic [63:0] HALF_TURN_RND = 64'd900000000;
    // floor(2^62 / 1.8e9), the reciprocal used for the degree scaling.
    localparam logic [31:0] DIV_RECIP    = 32'd2562047788;
    localparam logic [29:0] RADIUS_CM    = 30'd637100000;
    localparam logic [30:0] DIST_MAX_CM  = 31'd2001508680;

    // floor(atan(2^-i) * 2^30); from stage ten on this is 2^(30-i) - 1.
    function automatic logic [30:0] atan_entry(input int unsigned i);
        logic [30:0] r;
        case (i)
            0: r = 31'd843314856;
            1: r = 31'd497837829;
            2: r = 31'd263043837;
            3: r = 31'd133525158;
            4: r = 31'd67021686;
            5: r = 31'd33543515;
            6: r = 31'd16775850;
            7: r = 31'd8388437;
            8: r = 31'd4194282;
            9: r = 31'd2097149;
            default: r = (i < 30) ? ((31'd1 << (30 - i)) - 31'd1) : 31'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hav_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine distance channels
// Valid/ready channels for point pairs and for distances.
// ----------------------------------------------------------------------------
interface hav_pair_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] first_lat;
    logic signed [31:0] first_lon;
    logic signed [30:0] second_lat;
    logic signed [31:0] second_lon;

    modport source (output valid, output first_lat, output first_lon,
                    output second_lat, output second_lon, input ready);
    modport sink   (input valid, input first_lat, input first_lon,
                    input second_lat, input second_lon, output ready);
endinterface

interface hav_dist_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_cm;

    modport source (output valid, output distance_cm, input ready);
    modport sink   (input valid, input distance_cm, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/haversine_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine great-circle distance core
// Fully pipelined distance between two points given in 1e-7 degree units.
// ----------------------------------------------------------------------------
// The core takes one point-pair beat per clock cycle while input ready is
// high and returns one distance beat in centimetres for each, in order.
// The pipeline is mostly a chain of one-step-per-stage units: a rotation
// CORDIC for the sines and cosines, a 31-stage square root and a vectoring
// CORDIC for the arctangent, each CORDIC with CORDIC_STAGES stages (32 by
// default). The division in the degree-to-radian scaling takes three
// stages (a reciprocal multiplication, a remainder and a small
// correction), and the products, clamps and final scaling take the rest.
// Every stage moves on a single pipeline enable; a one-beat skid register
// behind the output register lets the pipeline keep moving while a
// finished distance waits to be taken, until the next finished beat lands
// in the skid register, after which input ready drops until it drains.
// The core holds no state between beats and needs no configuration.
// ----------------------------------------------------------------------------
module haversine_distance_core #(
    parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    hav_pair_if.sink    pair,
    hav_dist_if.source  result
);

    localparam int AW   = hav_pkg::AW;
    localparam int NS   = CORDIC_STAGES;
    localparam int SQB  = 31;
    // Stage holding a from the clamp, just ahead of the square roots.
    localparam int ST_P3 = 11 + NS;
    localparam int NST   = 46 + 2 * NS;

    localparam logic [33:0] DIV1 = 34'(hav_pkg::HALF_TURN);
    localparam logic [33:0] DIV2 = DIV1 << 1;
    localparam logic [33:0] DIV3 = DIV1 + DIV2;

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together while the skid
    // register is empty; valid bits shift alongside the data.
    // ------------------------------------------------------------------
    logic           pipe_en;
    logic [NST-1:0] vld_reg;
    logic           o_vld_reg;
    logic           o_vld_next;
    logic           s_vld_reg;
    logic           s_vld_next;

    assign pipe_en    = !s_vld_reg;
    assign pair.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[NST-2:0], pair.valid};
        end
    end

    // ------------------------------------------------------------------
    // Input stage: sign and magnitude of the four angles.
    // Lanes are first latitude, first longitude, second latitude and
    // second longitude.
    // ------------------------------------------------------------------
    logic signed [31:0] in_deg [4];
    logic               in_neg_reg [4];
    logic [31:0]        in_mag_reg [4];

    assign in_deg[0] = {pair.first_lat[30], pair.first_lat};
    assign in_deg[1] = pair.first_lon;
    assign in_deg[2] = {pair.second_lat[30], pair.second_lat};
    assign in_deg[3] = pair.second_lon;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                in_neg_reg[l] <= in_deg[l][31];
                in_mag_reg[l] <= in_deg[l][31] ? 32'(-in_deg[l]) : 32'(in_deg[l]);
            end
        end
    end

    // Magnitude times pi, with half the divisor added for rounding.
    logic        mu_neg_reg [4];
    logic [63:0] mu_num_reg [4];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                mu_neg_reg[l] <= in_neg_reg[l];
                mu_num_reg[l] <= 64'(in_mag_reg[l]) * 64'(hav_pkg::PI_Q30_U)
                                 + hav_pkg::HALF_TURN_RND;
            end
        end
    end

    // ------------------------------------------------------------------
    // Division by 1.8e9 in three stages. The top 33 bits of the numerator
    // times floor(2^62 / 1.8e9) give a quotient estimate that is at most
    // three short; the remainder, which is below 2^34, is formed from the
    // low bits only, and compares against one, two and three divisors
    // supply the missing count.
    // ------------------------------------------------------------------
    logic [64:0] dq_prod    [4];
    logic [31:0] dq_q_reg   [4];
    logic [33:0] dq_n_reg   [4];
    logic        dq_neg_reg [4];
    logic [33:0] dr_prod    [4];
    logic [31:0] dr_q_reg   [4];
    logic [33:0] dr_r_reg   [4];
    logic        dr_neg_reg [4];
    logic [31:0] dv_q_reg   [4];
    logic        dv_neg_reg [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            dq_prod[l] = 65'(mu_num_reg[l][62:30]) * 65'(hav_pkg::DIV_RECIP);
            dr_prod[l] = 34'(dq_q_reg[l]) * 34'(hav_pkg::HALF_TURN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                dq_q_reg[l]   <= dq_prod[l][63:32];
                dq_n_reg[l]   <= mu_num_reg[l][33:0];
                dq_neg_reg[l] <= mu_neg_reg[l];
                dr_q_reg[l]   <= dq_q_reg[l];
                dr_r_reg[l]   <= dq_n_reg[l] - dr_prod[l];
                dr_neg_reg[l] <= dq_neg_reg[l];
                dv_q_reg[l]   <= dr_q_reg[l] + 32'(dr_r_reg[l] >= DIV1)
                                 + 32'(dr_r_reg[l] >= DIV2) + 32'(dr_r_reg[l] >= DIV3);
                dv_neg_reg[l] <= dr_neg_reg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Signed angles in radians, then differences and cosine folding, then
    // wrapping of the differences into [-pi, pi) and halving.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] rad_reg [4];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rad_reg[l] <= dv_neg_reg[l]
                    ? -$signed({2'b00, dv_q_reg[l]})
                    :  $signed({2'b00, dv_q_reg[l]});
            end
        end
    end

    logic signed [AW-1:0] df_reg [2];
    logic signed [AW-1:0] lf_reg [2];
    logic                 lfl_reg [2];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            df_reg[0] <= rad_reg[2] - rad_reg[0];
            df_reg[1] <= rad_reg[3] - rad_reg[1];
            for (int l = 0; l < 2; l++)
            begin
                // A latitude past a pole is folded back by pi; its cosine
                // then changes sign.
                if (rad_reg[2*l] > hav_pkg::HALF_PI_Q30)
                begin
                    lf_reg[l]  <= rad_reg[2*l] - hav_pkg::PI_Q30;
                    lfl_reg[l] <= 1'b1;
                end
                else if (rad_reg[2*l] < -hav_pkg::HALF_PI_Q30)
                begin
                    lf_reg[l]  <= rad_reg[2*l] + hav_pkg::PI_Q30;
                    lfl_reg[l] <= 1'b1;
                end
                else
                begin
                    lf_reg[l]  <= rad_reg[2*l];
                    lfl_reg[l] <= 1'b0;
                end
            end
        end
    end

    logic signed [AW-1:0] ang_reg [4];
    logic                 afl_reg [2];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (df_reg[l] >= hav_pkg::PI_Q30)
                begin
                    ang_reg[l] <= (df_reg[l] - hav_pkg::TWO_PI_Q30) >>> 1;
                end
                else if (df_reg[l] < -hav_pkg::PI_Q30)
                begin
                    ang_reg[l] <= (df_reg[l] + hav_pkg::TWO_PI_Q30) >>> 1;
                end
                else
                begin
                    ang_reg[l] <= df_reg[l] >>> 1;
                end
                ang_reg[l+2] <= lf_reg[l];
                afl_reg[l]   <= lfl_reg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation CORDIC, one iteration per stage, four lanes: the half
    // latitude difference, the half longitude difference and the two
    // folded latitudes.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] rx_reg  [NS][4];
    logic signed [AW-1:0] ry_reg  [NS][4];
    logic signed [AW-1:0] rz_reg  [NS][4];
    logic                 rf_reg  [NS][2];
    logic signed [AW-1:0] rx_next [NS][4];
    logic signed [AW-1:0] ry_next [NS][4];
    logic signed [AW-1:0] rz_next [NS][4];
    logic                 rf_next [NS][2];

    always_comb
    begin
        logic signed [AW-1:0] xi;
        logic signed [AW-1:0] yi;
        logic signed [AW-1:0] zi;
        logic signed [AW-1:0] at;
        for (int k = 0; k < NS; k++)
        begin
            at = $signed({3'b000, hav_pkg::atan_entry(k)});
            for (int l = 0; l < 4; l++)
            begin
                if (k == 0)
                begin
                    xi = hav_pkg::GAIN_Q30;
                    yi = '0;
                    zi = ang_reg[l];
                end
                else
                begin
                    xi = rx_reg[k > 0 ? k - 1 : 0][l];
                    yi = ry_reg[k > 0 ? k - 1 : 0][l];
                    zi = rz_reg[k > 0 ? k - 1 : 0][l];
                end
                if (zi >= 0)
                begin
                    rx_next[k][l] = xi - (yi >>> k);
                    ry_next[k][l] = yi + (xi >>> k);
                    rz_next[k][l] = zi - at;
                end
                else
                begin
                    rx_next[k][l] = xi + (yi >>> k);
                    ry_next[k][l] = yi - (xi >>> k);
                    rz_next[k][l] = zi + at;
                end
            end
            for (int l = 0; l < 2; l++)
            begin
                rf_next[k][l] = (k == 0) ? afl_reg[l] : rf_reg[k > 0 ? k - 1 : 0][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            rf_reg <= rf_next;
        end
    end

    // ------------------------------------------------------------------
    // Products: a = sin^2(dlat/2) + cos(lat1) * cos(lat2) * sin^2(dlon/2),
    // each product floored back to Q30, then clamped to [0, 1].
    // ------------------------------------------------------------------
    logic signed [AW-1:0] sv_reg [4];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sv_reg[0] <= ry_reg[NS-1][0];
            sv_reg[1] <= ry_reg[NS-1][1];
            sv_reg[2] <= rf_reg[NS-1][0] ? -rx_reg[NS-1][2] : rx_reg[NS-1][2];
            sv_reg[3] <= rf_reg[NS-1][1] ? -rx_reg[NS-1][3] : rx_reg[NS-1][3];
        end
    end

    logic signed [34:0] p1_sl_reg;
    logic signed [34:0] p1_sg_reg;
    logic signed [34:0] p1_cc_reg;
    logic signed [67:0] p1_sl_prod;
    logic signed [67:0] p1_sg_prod;
    logic signed [67:0] p1_cc_prod;

    assign p1_sl_prod = sv_reg[0] * sv_reg[0];
    assign p1_sg_prod = sv_reg[1] * sv_reg[1];
    assign p1_cc_prod = sv_reg[2] * sv_reg[3];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            p1_sl_reg <= 35'(p1_sl_prod >>> 30);
            p1_sg_reg <= 35'(p1_sg_prod >>> 30);
            p1_cc_reg <= 35'(p1_cc_prod >>> 30);
        end
    end

    logic signed [34:0] p2_sl_reg;
    logic signed [34:0] p2_t_reg;
    logic signed [69:0] p2_prod;

    assign p2_prod = p1_cc_reg * p1_sg_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            p2_sl_reg <= p1_sl_reg;
            p2_t_reg  <= 35'(p2_prod >>> 30);
        end
    end

    logic signed [35:0] p3_sum;
    logic [30:0]        p3_a;
    logic [30:0]        sa_reg;
    logic [30:0]        sb_reg;

    always_comb
    begin
        p3_sum = 36'(p2_sl_reg) + 36'(p2_t_reg);
        if (p3_sum < 0)
        begin
            p3_a = '0;
        end
        else if (p3_sum > $signed({5'b00000, hav_pkg::ONE_Q30}))
        begin
            p3_a = hav_pkg::ONE_Q30;
        end
        else
        begin
            p3_a = p3_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sa_reg <= p3_a;
            sb_reg <= hav_pkg::ONE_Q30 - p3_a;
        end
    end

    // ------------------------------------------------------------------
    // Two restoring square roots, one result bit per stage: sqrt(a) in
    // lane 0 and sqrt(1 - a) in lane 1.
    // ------------------------------------------------------------------
    logic [60:0] sq_n_reg  [SQB][2];
    logic [61:0] sq_r_reg  [SQB][2];
    logic [60:0] sq_n_next [SQB][2];
    logic [61:0] sq_r_next [SQB][2];

    always_comb
    begin
        logic [60:0] ni;
        logic [61:0] ri;
        logic [61:0] rb;
        logic [61:0] bitv;
        for (int k = 0; k < SQB; k++)
        begin
            bitv = 62'd1 << (60 - 2 * k);
            for (int l = 0; l < 2; l++)
            begin
                if (k == 0)
                begin
                    ni = {(l == 0) ? sa_reg : sb_reg, 30'd0};
                    ri = '0;
                end
                else
                begin
                    ni = sq_n_reg[k > 0 ? k - 1 : 0][l];
                    ri = sq_r_reg[k > 0 ? k - 1 : 0][l];
                end
                rb = ri + bitv;
                if ({1'b0, ni} >= rb)
                begin
                    sq_n_next[k][l] = 61'({1'b0, ni} - rb);
                    sq_r_next[k][l] = (ri >> 1) + bitv;
                end
                else
                begin
                    sq_n_next[k][l] = ni;
                    sq_r_next[k][l] = ri >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sq_n_reg <= sq_n_next;
            sq_r_reg <= sq_r_next;
        end
    end

    // ------------------------------------------------------------------
    // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)).
    // ------------------------------------------------------------------
    logic signed [AW-1:0] vx_reg  [NS];
    logic signed [AW-1:0] vy_reg  [NS];
    logic signed [AW-1:0] vz_reg  [NS];
    logic signed [AW-1:0] vx_next [NS];
    logic signed [AW-1:0] vy_next [NS];
    logic signed [AW-1:0] vz_next [NS];

    always_comb
    begin
        logic signed [AW-1:0] xi;
        logic signed [AW-1:0] yi;
        logic signed [AW-1:0] zi;
        logic signed [AW-1:0] at;
        for (int k = 0; k < NS; k++)
        begin
            at = $signed({3'b000, hav_pkg::atan_entry(k)});
            if (k == 0)
            begin
                xi = $signed({3'b000, sq_r_reg[SQB-1][1][30:0]});
                yi = $signed({3'b000, sq_r_reg[SQB-1][0][30:0]});
                zi = '0;
            end
            else
            begin
                xi = vx_reg[k > 0 ? k - 1 : 0];
                yi = vy_reg[k > 0 ? k - 1 : 0];
                zi = vz_reg[k > 0 ? k - 1 : 0];
            end
            if (yi > 0)
            begin
                vx_next[k] = xi + (yi >>> k);
                vy_next[k] = yi - (xi >>> k);
                vz_next[k] = zi + at;
            end
            else
            begin
                vx_next[k] = xi - (yi >>> k);
                vy_next[k] = yi + (xi >>> k);
                vz_next[k] = zi - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            vz_reg <= vz_next;
        end
    end

    // ------------------------------------------------------------------
    // Central angle c = 2 * atan2, clamped at zero, scaled by the radius
    // in centimetres, rounded half up and saturated at half the
    // circumference.
    // ------------------------------------------------------------------
    logic [31:0] c_reg;
    logic [61:0] dm_reg;
    logic [30:0] fin_reg;
    logic [62:0] fin_sum;
    logic [32:0] fin_dist;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c_reg  <= vz_reg[NS-1][AW-1] ? 32'd0 : {vz_reg[NS-1][30:0], 1'b0};
            dm_reg <= 62'(c_reg) * 62'(hav_pkg::RADIUS_CM);
        end
    end

    assign fin_sum  = 63'(dm_reg) + (63'd1 << 29);
    assign fin_dist = fin_sum[62:30];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            fin_reg <= (fin_dist > 33'(hav_pkg::DIST_MAX_CM)) ? hav_pkg::DIST_MAX_CM
                                                              : fin_dist[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register with a one-beat skid register behind it. A beat
    // leaving the pipeline while the output is stalled lands in the skid
    // register, which then holds the pipeline until it drains.
    // ------------------------------------------------------------------
    logic [30:0] o_dist_reg;
    logic [30:0] s_dist_reg;
    logic        o_free;

    assign o_free = !o_vld_reg || result.ready;

    always_comb
    begin
        o_vld_next = o_vld_reg;
        s_vld_next = s_vld_reg;
        if (o_free)
        begin
            o_vld_next = s_vld_reg || vld_reg[NST-1];
            s_vld_next = 1'b0;
        end
        else if (pipe_en && vld_reg[NST-1])
        begin
            s_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else
        begin
            o_vld_reg <= o_vld_next;
            s_vld_reg <= s_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_free)
        begin
            o_dist_reg <= s_vld_reg ? s_dist_reg : fin_reg;
        end
        else if (pipe_en)
        begin
            s_dist_reg <= fin_reg;
        end
    end

    assign result.valid       = o_vld_reg;
    assign result.distance_cm = o_dist_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_vld_reg |-> o_vld_reg)
        else $error("skid register holds a beat while the output is empty");

    a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_vld_reg) |-> $past(o_vld_reg && !result.ready))
        else $error("skid register filled without an output stall");

    a_dist_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.distance_cm <= hav_pkg::DIST_MAX_CM))
        else $error("distance above half the circumference");

    a_root_inputs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P3] |-> ((32'(sa_reg) + 32'(sb_reg)) == 32'(hav_pkg::ONE_Q30)))
        else $error("square-root inputs do not sum to one");

    a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!pipe_en && vld_reg[NST-1]) |=> vld_reg[NST-1])
        else $error("pipeline lost a beat while held");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine distance core testbench
// Feeds point pairs through the core with bursty input and a stalling output
// side, predicts every distance with an independent fixed-point model and
// compares the distances in order as they leave the core.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  STAGES      = hav_pkg::CORDIC_STAGES_DEF;
    localparam int  LATENCY     = 46 + 2 * STAGES;
    localparam int  RANDOM_BEATS = 1200;
    localparam int  LONG_HOLD   = 4 * LATENCY;

    localparam longint PI_FIX    = 64'sd3373259426;
    localparam longint TWO_PI    = 2 * PI_FIX;
    localparam longint HALF_PI   = PI_FIX / 2;
    localparam longint UNIT      = 64'sd1 << 30;
    localparam longint START_X   = 64'sd652032874;
    localparam longint RADIUS    = 64'sd637100000;
    localparam longint FAR_LIMIT = 64'sd2001508680;
    localparam longint DEG7_HALF = 64'sd1800000000;

    logic clk;
    logic rst_n;

    hav_pair_if pair ();
    hav_dist_if result ();

    haversine_distance_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair.sink),
        .result (result.source)
    );

    // ------------------------------------------------------------------------
    // Distance predictor
    // ------------------------------------------------------------------------

    // Arctangent of 2^-i in Q30, truncated; exact powers of two less one
    // from stage ten on, nothing at all from stage thirty.
    function automatic longint arc_step(input int i);
        longint head [10] = '{843314856, 497837829, 263043837, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10)
            return head[i];
        if (i < 30)
            return (64'sd1 << (30 - i)) - 1;
        return 0;
    endfunction

    // Degrees times 1e7 into Q30 radians, rounded half away from zero.
    function automatic longint radians_of(input longint deg7);
        longint unsigned mag;
        longint unsigned q;
        mag = (deg7 < 0) ? longint'(-deg7) : longint'(deg7);
        q   = (mag * longint'(PI_FIX) + longint'(DEG7_HALF / 2)) / longint'(DEG7_HALF);
        return (deg7 < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint wrap_half_turn(input longint d);
        longint r;
        r = d % TWO_PI;
        if (r >= PI_FIX)
            r -= TWO_PI;
        if (r < -PI_FIX)
            r += TWO_PI;
        return r;
    endfunction

    function automatic void rotate(input longint ang, output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        x = START_X;
        y = 0;
        z = ang;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
        end
        sn = y;
        cs = x;
    endfunction

    // Cosine of any angle: beyond a quarter turn the angle is folded by a
    // half turn and the sign of the cosine flipped.
    function automatic longint cosine_of(input longint ang);
        longint s, c;
        bit     flip;
        flip = 1'b0;
        if (ang > HALF_PI)
        begin
            ang -= PI_FIX; flip = 1'b1;
        end
        else if (ang < -HALF_PI)
        begin
            ang += PI_FIX; flip = 1'b1;
        end
        rotate(ang, s, c);
        return flip ? -c : c;
    endfunction

    function automatic longint half_sine(input longint d);
        longint s, c;
        rotate(wrap_half_turn(d) >>> 1, s, c);
        return s;
    endfunction

    function automatic longint arctan2(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint root_of(input longint v);
        longint unsigned n, res, b;
        n   = longint'(v) << 30;
        res = 0;
        b   = 64'd1 << 60;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n  -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [30:0] distance_of(input logic signed [30:0] lat_a,
                                                input logic signed [31:0] lon_a,
                                                input logic signed [30:0] lat_b,
                                                input logic signed [31:0] lon_b);
        longint la, oa, lb, ob, sl, sg, cc, a, c, d;
        la = radians_of(longint'(lat_a));
        oa = radians_of(longint'(lon_a));
        lb = radians_of(longint'(lat_b));
        ob = radians_of(longint'(lon_b));
        sl = half_sine(lb - la);
        sg = half_sine(ob - oa);
        cc = (cosine_of(la) * cosine_of(lb)) >>> 30;
        a  = ((sl * sl) >>> 30) + ((cc * ((sg * sg) >>> 30)) >>> 30);
        // Rounding can push a slightly outside the unit interval.
        if (a < 0)
            a = 0;
        if (a > UNIT)
            a = UNIT;
        c = 2 * arctan2(root_of(a), root_of(UNIT - a));
        if (c < 0)
            c = 0;
        d = (c * RADIUS + (64'sd1 << 29)) >>> 30;
        if (d > FAR_LIMIT)
            d = FAR_LIMIT;
        return d[30:0];
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: one predicted distance per accepted point pair, in order.
    // ------------------------------------------------------------------------
    class distance_board;
        logic [30:0] awaited [$];
        int          faults;
        int          taken;

        function void note_pair(logic signed [30:0] lat_a, logic signed [31:0] lon_a,
                                logic signed [30:0] lat_b, logic signed [31:0] lon_b);
            awaited.push_back(distance_of(lat_a, lon_a, lat_b, lon_b));
            taken++;
        endfunction

        function void check_distance(logic [30:0] got);
            logic [30:0] want;
            if (awaited.size() == 0)
            begin
                $error("distance_cm: unexpected beat, actual %0d", got);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (got !== want)
            begin
                $error("distance_cm: expected %0d, actual %0d", want, got);
                faults++;
            end
        endfunction
    endclass

    distance_board board;

    // ------------------------------------------------------------------------
    // Clock, reset and the run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Both channels are watched at the rising edge, where a beat moves when
    // valid and ready are high together.
    always @(posedge clk)
    begin
        if (rst_n && pair.valid && pair.ready)
            board.note_pair(pair.first_lat, pair.first_lon, pair.second_lat, pair.second_lon);
        if (rst_n && result.valid && result.ready)
            board.check_distance(result.distance_cm);
    end

    // ------------------------------------------------------------------------
    // Output side: the ready pattern changes mode every so often, and once,
    // part way through the random beats, it holds off long enough for the
    // pipeline and its skid register to fill and stall the input.
    // ------------------------------------------------------------------------
    bit long_hold_done;

    initial
    begin
        int mode;
        result.ready   = 1'b0;
        long_hold_done = 1'b0;
        mode           = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && board.taken >= 400)
            begin
                result.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: result.ready = 1'b1;
                1: result.ready = $urandom_range(0, 1);
                2: result.ready = ($urandom_range(0, 3) == 0);
                default: result.ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    int burst_left;

    // Offers one point pair from the next falling edge until it is taken.
    task automatic offer_pair(input logic signed [30:0] lat_a, input logic signed [31:0] lon_a,
                              input logic signed [30:0] lat_b, input logic signed [31:0] lon_b);
        @(negedge clk);
        pair.first_lat  = lat_a;
        pair.first_lon  = lon_a;
        pair.second_lat = lat_b;
        pair.second_lon = lon_b;
        pair.valid      = 1'b1;
        do
            @(posedge clk);
        while (!pair.ready);
    endtask

    // Between bursts the sender drops valid and goes quiet for a random pause.
    task automatic pace_sender;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 8);
        @(negedge clk);
        pair.valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
    endtask

    task automatic wait_drained;
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [30:0] pick_lat();
        case ($urandom_range(0, 9))
            0:       return 31'($urandom());                     // any bit pattern
            1:       return $urandom_range(0, 1) ? 31'sd900000000 : -31'sd900000000;
            default: return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_lon();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sd1800000000 : -32'sd1800000000;
            default: return 32'($signed($urandom_range(0, 1800000000)) * 2
                                - 32'sd1800000000 + $signed($urandom_range(0, 1)));
        endcase
    endfunction

    // Random pairs: mostly independent points, some close neighbours, some
    // near-antipodal pairs that drive the distance towards saturation.
    task automatic offer_random_pair;
        logic signed [30:0] la, lb;
        logic signed [31:0] oa, ob;
        la = pick_lat();
        oa = pick_lon();
        case ($urandom_range(0, 5))
            0:
            begin
                lb = 31'(la + $signed($urandom_range(0, 2000)) - 1000);
                ob = 32'(oa + $signed($urandom_range(0, 2000)) - 1000);
            end
            1:
            begin
                lb = 31'(-la + $signed($urandom_range(0, 20)) - 10);
                ob = 32'(oa + 32'sd1800000000 + $signed($urandom_range(0, 20)) - 10);
            end
            default:
            begin
                lb = pick_lat();
                ob = pick_lon();
            end
        endcase
        offer_pair(la, oa, lb, ob);
        pace_sender();
    endtask

    initial
    begin
        board           = new();
        burst_left      = 0;
        rst_n           = 1'b0;
        pair.valid      = 1'b0;
        pair.first_lat  = '0;
        pair.first_lon  = '0;
        pair.second_lat = '0;
        pair.second_lon = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: identical points, the field extremes, poles,
        // antipodes, longitude wrap across the date line, latitudes past the
        // poles (negative cosine) and the saturating half circumference.
        offer_pair(0, 0, 0, 0);
        offer_pair(0, 0, 0, 1);
        offer_pair(0, 0, 1, 0);
        offer_pair(900000000, 0, -900000000, 0);
        offer_pair(0, 0, 0, 1800000000);
        offer_pair(0, -1800000000, 0, 1800000000);
        offer_pair(0, 1799999999, 0, -1799999999);
        offer_pair(0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000);
        offer_pair(31'sh3FFF_FFFF, 0, 31'sh4000_0000, 0);
        offer_pair(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000);
        offer_pair(1000000000, 0, 0, 0);
        offer_pair(-1000000000, 500000000, 1000000000, -500000000);
        offer_pair(450000000, 900000000, -450000000, -900000000);
        offer_pair(515000000, -1200000, 407000000, -740000000);
        offer_pair(0, 0, 0, -1800000000);
        offer_pair(-900000000, 1800000000, 900000000, -1800000000);
        offer_pair(1, 1, -1, -1);
        offer_pair(899999999, 123456789, 899999999, -1234567890);

        // Pause until the pipeline has drained completely.
        pace_sender();
        @(negedge clk);
        pair.valid = 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            offer_random_pair();
            // A second full drain in the middle of the random part.
            if (n == RANDOM_BEATS / 2)
            begin
                @(negedge clk);
                pair.valid = 1'b0;
                wait_drained();
            end
        end

        @(negedge clk);
        pair.valid = 1'b0;
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);

        if (board.faults == 0 && board.awaited.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
